// File: src/terminal_line_editor_with_history_assert.svh
// Assertion macros for the line editor.
`ifndef TERMINAL_LINE_EDITOR_WITH_HISTORY_ASSERT_SVH
`define TERMINAL_LINE_EDITOR_WITH_HISTORY_ASSERT_SVH

// Implication checked on every rising clock edge, skipped while in reset.
`define TLE_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, also skipped while in reset.
`define TLE_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: src/tle_pkg.sv
`default_nettype none
package tle_pkg;

    localparam logic [7:0] KEY_ESC = 8'd27;
    localparam logic [7:0] KEY_DEL = 8'd127;

    // Result kinds
    localparam logic [2:0] KIND_STATUS = 3'd0;
    localparam logic [2:0] KIND_BYTE   = 3'd1;
    localparam logic [2:0] KIND_DONE   = 3'd2;
    localparam logic [2:0] KIND_INTR   = 3'd3;
    localparam logic [2:0] KIND_EOF    = 3'd4;

    // Escape decoder states
    typedef enum logic [3:0] {
        ESC_IDLE = 4'd0, ESC_START = 4'd1, ESC_CSI = 4'd2, ESC_SS3 = 4'd3,
        ESC_ONE = 4'd4, ESC_THREE = 4'd5, ESC_FOUR = 4'd6, ESC_SKIP = 4'd7,
        ESC_SEMI = 4'd8, ESC_MOD = 4'd9
    } t_esc;

    // Sequencer states
    typedef enum logic [3:0] {
        S_IDLE, S_DECODE, S_INS_RD, S_INS_WR, S_DEL_RD, S_DEL_WR,
        S_TRIM_RD, S_TRIM_CHK, S_CMP_RD, S_CMP_CHK, S_COPY_RD, S_COPY_WR,
        S_EMIT_RD, S_EMIT, S_OUT
    } t_seq;

    // Pending operation kinds
    typedef enum logic [2:0] {
        OP_NONE, OP_INSERT, OP_DELETE, OP_ENTER, OP_RECALL
    } t_op;

endpackage
`default_nettype wire

// File: src/terminal_line_editor_with_history.sv
`default_nettype none
// Line editor for raw terminal key bytes: decodes ESC [ / ESC O sequences,
// edits a line with a cursor, keeps a ring of HISTORY_DEPTH recent lines and
// on Enter emits the trimmed line byte by byte followed by a done beat. One
// byte is handled at a time; o_ready is low while it is worked on and until
// its last result beat has been taken. Insert and delete walk the line one
// character at a time (a read state, then a write state); recall copies one
// character at a time; Enter trims, compares and copies a character at a time,
// then emits the line one byte beat at a time, held by receiver stalls. The
// line memory has a read port and a write port; the history memory is
// single-port. No clearing pass is needed after reset.
module terminal_line_editor_with_history
    import tle_pkg::*;
#(
    parameter int LINE_CAP      = 63,
    parameter int HISTORY_DEPTH = 16
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    output logic            o_ready,
    input  wire logic [7:0] i_key_byte,
    output logic            o_valid,
    input  wire logic       i_ready,
    output logic [2:0]      o_kind,
    output logic [7:0]      o_char_out,
    output logic [5:0]      o_cursor_pos,
    output logic [5:0]      o_line_len,
    output logic            o_overflow,
    output logic            o_last
);

    localparam int LW = $clog2(LINE_CAP + 1);
    localparam int HW = $clog2(HISTORY_DEPTH);
    localparam int HD = HISTORY_DEPTH * LINE_CAP;
    localparam int AW = $clog2(HD);
    localparam logic [LW-1:0] CAP = LW'(LINE_CAP);
    localparam logic [HW-1:0] LAST_SLOT = HW'(HISTORY_DEPTH - 1);

    // Memories
    logic [7:0]    r_line_mem [LINE_CAP];
    logic [7:0]    r_hist_mem [HD];
    logic [LW-1:0] r_hlen_mem [HISTORY_DEPTH];
    logic [HISTORY_DEPTH-1:0] r_hvalid, n_hvalid;

    t_seq          r_state, n_state;
    t_esc          r_esc, n_esc;
    t_op           r_op, n_op;
    logic [7:0]    r_key, n_key;
    logic [LW-1:0] r_cursor, n_cursor, r_len, n_len, r_idx, n_idx;
    logic [HW-1:0] r_wslot, n_wslot, r_vslot, n_vslot, r_slot, n_slot;
    logic [AW-1:0] r_hbase, n_hbase;
    logic          r_store, n_store;
    logic [2:0]    r_kind, n_kind;
    logic [7:0]    r_chr, n_chr;
    logic          r_ovf, n_ovf, r_last, n_last, r_ovalid, n_ovalid;
    logic [5:0]    r_ocur, n_ocur, r_olen, n_olen;

    // Memory port controls
    logic          line_we, hist_we, hlen_we;
    logic [LW-1:0] line_wa, line_ra;
    logic [7:0]    line_wd;
    logic [AW-1:0] hist_a;
    logic [7:0]    r_line_rd, r_hist_rd;
    logic [LW-1:0] r_hlen_rd;
    logic [HW-1:0] hlen_ra;
    logic [HW-1:0] prv_slot, up_slot, dn_slot;

    always_ff @(posedge i_clk) begin
        if (line_we) r_line_mem[line_wa] <= line_wd;
        r_line_rd <= r_line_mem[line_ra];
        if (hist_we) r_hist_mem[hist_a] <= r_line_rd;
        r_hist_rd <= r_hist_mem[hist_a];
        if (hlen_we) r_hlen_mem[r_wslot] <= r_len;
        r_hlen_rd <= r_hlen_mem[hlen_ra];
    end

    // Slot arithmetic
    always_comb begin
        prv_slot = (r_wslot == '0) ? LAST_SLOT : r_wslot - 1'b1;
        up_slot  = (r_vslot == '0) ? LAST_SLOT : r_vslot - 1'b1;
        dn_slot  = (r_vslot == LAST_SLOT) ? '0 : r_vslot + 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_esc    <= ESC_IDLE;
            r_cursor <= '0;
            r_len    <= '0;
            r_wslot  <= '0;
            r_vslot  <= '0;
            r_hvalid <= '0;
            r_ovalid <= 1'b0;
            r_op     <= OP_NONE;
        end else begin
            r_state  <= n_state;
            r_esc    <= n_esc;
            r_cursor <= n_cursor;
            r_len    <= n_len;
            r_wslot  <= n_wslot;
            r_vslot  <= n_vslot;
            r_hvalid <= n_hvalid;
            r_ovalid <= n_ovalid;
            r_op     <= n_op;
        end
        r_key   <= n_key;
        r_idx   <= n_idx;
        r_slot  <= n_slot;
        r_hbase <= n_hbase;
        r_store <= n_store;
        r_kind  <= n_kind;
        r_chr   <= n_chr;
        r_ovf   <= n_ovf;
        r_last  <= n_last;
        r_ocur  <= n_ocur;
        r_olen  <= n_olen;
    end

    // Sequencer
    always_comb begin
        n_state = r_state; n_esc = r_esc; n_op = r_op; n_key = r_key;
        n_cursor = r_cursor; n_len = r_len; n_idx = r_idx;
        n_wslot = r_wslot; n_vslot = r_vslot; n_slot = r_slot;
        n_hbase = r_hbase; n_store = r_store; n_hvalid = r_hvalid;
        n_kind = r_kind; n_chr = r_chr; n_ovf = r_ovf; n_last = r_last;
        n_ocur = r_ocur; n_olen = r_olen; n_ovalid = r_ovalid;
        line_we = 1'b0; line_wa = r_idx; line_wd = r_line_rd;
        line_ra = r_idx; hist_we = 1'b0; hlen_we = 1'b0;
        hist_a = AW'(r_hbase + AW'(r_idx)); hlen_ra = prv_slot;
        o_ready = 1'b0;

        if (r_ovalid && i_ready) n_ovalid = 1'b0;

        case (r_state)
            S_IDLE: begin
                // Take a new byte only once the previous result beat is gone
                o_ready = !r_ovalid;
                if (i_valid && !r_ovalid) begin
                    n_key = i_key_byte;
                    n_op = OP_NONE;
                    n_ovf = 1'b0;
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                n_state = S_OUT;
                n_kind = KIND_STATUS;
                n_chr = 8'd0;
                n_last = 1'b1;
                if (r_key == KEY_ESC) begin
                    n_esc = ESC_START;
                end else begin
                    n_esc = ESC_IDLE;
                    case (r_esc)
                        ESC_START: begin
                            if (r_key == "[") n_esc = ESC_CSI;
                            else if (r_key == "O") n_esc = ESC_SS3;
                        end
                        ESC_CSI: begin
                            case (r_key)
                                "A": if (up_slot != r_wslot && r_hvalid[up_slot]) begin
                                    n_slot = up_slot; n_op = OP_RECALL;
                                end
                                "B": if (r_vslot != r_wslot) begin
                                    n_slot = dn_slot; n_op = OP_RECALL;
                                end
                                "C": if (r_cursor < r_len) n_cursor = r_cursor + 1'b1;
                                "D": if (r_cursor != '0) n_cursor = r_cursor - 1'b1;
                                "1": n_esc = ESC_ONE;
                                "3": n_esc = ESC_THREE;
                                "4": n_esc = ESC_FOUR;
                                "2", "5", "6": n_esc = ESC_SKIP;
                                default: ;
                            endcase
                        end
                        ESC_SS3: begin
                            if (r_key == "H") n_cursor = '0;
                            if (r_key == "F") n_cursor = r_len;
                        end
                        ESC_ONE: begin
                            if (r_key == ";") n_esc = ESC_SEMI;
                            if (r_key == "~") n_cursor = '0;
                        end
                        ESC_THREE: if (r_key == "~") n_op = OP_DELETE;
                        ESC_FOUR: if (r_key == "~") n_cursor = r_len;
                        ESC_SKIP: ;
                        ESC_SEMI: if (r_key == "5") n_esc = ESC_MOD;
                        ESC_MOD: begin
                            if (r_key == "C") n_cursor = r_len;
                            if (r_key == "D") n_cursor = '0;
                        end
                        default: begin
                            // Idle: plain keys
                            if (r_key == KEY_DEL || r_key == 8'd8) begin
                                if (r_cursor != '0) begin
                                    n_cursor = r_cursor - 1'b1; n_op = OP_DELETE;
                                end
                            end else if (r_key < 8'd32) begin
                                case (r_key)
                                    8'd10, 8'd13: n_op = OP_ENTER;
                                    8'd3: begin
                                        n_kind = KIND_INTR;
                                        n_cursor = '0; n_len = '0; n_vslot = r_wslot;
                                    end
                                    8'd4: begin
                                        if (r_len == '0) begin
                                            n_kind = KIND_EOF; n_cursor = '0;
                                            n_vslot = r_wslot;
                                        end else n_op = OP_DELETE;
                                    end
                                    8'd1: n_cursor = '0;
                                    8'd2: if (r_cursor != '0) n_cursor = r_cursor - 1'b1;
                                    8'd5: n_cursor = r_len;
                                    8'd6: if (r_cursor < r_len) n_cursor = r_cursor + 1'b1;
                                    8'd14: if (r_vslot != r_wslot) begin
                                        n_slot = dn_slot; n_op = OP_RECALL;
                                    end
                                    8'd16: if (up_slot != r_wslot && r_hvalid[up_slot]) begin
                                        n_slot = up_slot; n_op = OP_RECALL;
                                    end
                                    default: ;
                                endcase
                            end else if (r_len >= CAP) begin
                                n_ovf = 1'b1;
                            end else begin
                                n_op = OP_INSERT;
                            end
                        end
                    endcase
                end
                // Launch the long operation chosen above
                case (n_op)
                    OP_INSERT: begin
                        n_idx = r_len; n_state = S_INS_RD;
                    end
                    OP_DELETE: begin
                        n_idx = n_cursor; n_state = S_DEL_RD;
                    end
                    OP_ENTER: begin
                        n_state = S_TRIM_RD; n_idx = r_len - 1'b1;
                    end
                    OP_RECALL: begin
                        n_vslot = n_slot;
                        n_idx = '0;
                        n_hbase = AW'(n_slot * LINE_CAP);
                        if (n_slot == r_wslot) begin
                            n_len = '0; n_cursor = '0; n_state = S_OUT;
                        end else n_state = S_COPY_RD;
                    end
                    default: ;
                endcase
                if (n_state == S_TRIM_RD && r_len == '0) n_state = S_CMP_RD;
                if (n_state == S_CMP_RD) n_idx = '0;
            end
            // Insert: shift right from the end, one char per read/write state pair
            S_INS_RD: begin
                line_ra = r_idx - 1'b1;
                n_state = S_INS_WR;
                if (r_idx == r_cursor) begin
                    line_we = 1'b1; line_wa = r_cursor; line_wd = r_key;
                    n_cursor = r_cursor + 1'b1; n_len = r_len + 1'b1;
                    n_state = S_OUT;
                end
            end
            S_INS_WR: begin
                line_we = 1'b1; line_wa = r_idx;
                n_idx = r_idx - 1'b1;
                n_state = S_INS_RD;
            end
            // Delete at cursor: shift left
            S_DEL_RD: begin
                line_ra = r_idx + 1'b1;
                if (r_idx >= r_len) n_state = S_OUT;
                else if (LW'(r_idx + 1'b1) >= r_len) begin
                    n_len = r_len - 1'b1; n_state = S_OUT;
                end else n_state = S_DEL_WR;
            end
            S_DEL_WR: begin
                line_we = 1'b1; line_wa = r_idx;
                n_idx = r_idx + 1'b1;
                n_state = S_DEL_RD;
            end
            // Enter: trim trailing spaces
            S_TRIM_RD: begin
                line_ra = r_len - 1'b1;
                n_state = S_TRIM_CHK;
            end
            S_TRIM_CHK: begin
                if (r_line_rd == 8'h20) begin
                    n_len = r_len - 1'b1;
                    n_state = (r_len == LW'(1)) ? S_CMP_RD : S_TRIM_RD;
                end else n_state = S_CMP_RD;
                n_idx = '0;
                n_hbase = AW'(prv_slot * LINE_CAP);
            end
            // Compare with newest entry; its stored length is read alongside
            S_CMP_RD: begin
                line_ra = r_idx;
                n_state = S_CMP_CHK;
                if (r_idx == '0) n_hbase = AW'(prv_slot * LINE_CAP);
            end
            S_CMP_CHK: begin
                n_hbase = AW'(r_wslot * LINE_CAP);
                if (r_len == '0 || (r_idx == '0 && r_line_rd == 8'h20)) begin
                    n_store = 1'b0; n_idx = '0; n_state = S_EMIT_RD;
                end else if (!r_hvalid[prv_slot] || r_hlen_rd != r_len
                             || r_hist_rd != r_line_rd) begin
                    n_store = 1'b1; n_idx = '0; n_state = S_COPY_RD;
                end else if (LW'(r_idx + 1'b1) == r_len) begin
                    n_store = 1'b0; n_idx = '0; n_state = S_EMIT_RD;
                end else begin
                    n_idx = r_idx + 1'b1;
                    n_hbase = AW'(prv_slot * LINE_CAP);
                    n_state = S_CMP_RD;
                end
            end
            // Copy line <-> history, direction set by the operation
            S_COPY_RD: begin
                line_ra = r_idx;
                n_state = S_COPY_WR;
                if (r_op == OP_RECALL) begin
                    hlen_ra = r_slot;
                end
            end
            S_COPY_WR: begin
                if (r_op == OP_ENTER) begin
                    if (r_idx == r_len) begin
                        hlen_we = 1'b1;
                        n_hvalid[r_wslot] = 1'b1;
                        n_wslot = (r_wslot == LAST_SLOT) ? '0 : r_wslot + 1'b1;
                        n_idx = '0; n_state = S_EMIT_RD;
                    end else begin
                        hist_we = 1'b1;
                        n_idx = r_idx + 1'b1; n_state = S_COPY_RD;
                    end
                end else begin
                    if (r_idx == r_hlen_rd) begin
                        n_len = r_hlen_rd; n_cursor = r_hlen_rd; n_state = S_OUT;
                    end else begin
                        line_we = 1'b1; line_wd = r_hist_rd;
                        n_idx = r_idx + 1'b1; n_state = S_COPY_RD;
                    end
                end
            end
            // Emit the finished line
            S_EMIT_RD: begin
                line_ra = r_idx;
                if (!r_ovalid) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                n_ocur = '0; n_olen = '0; n_ovf = 1'b0;
                n_ovalid = 1'b1;
                if (r_idx == r_len) begin
                    n_kind = KIND_DONE; n_chr = 8'd0; n_last = 1'b1;
                    n_cursor = '0; n_len = '0; n_esc = ESC_IDLE;
                    n_vslot = n_wslot; n_state = S_IDLE;
                    n_ovalid = 1'b1;
                end else begin
                    n_kind = KIND_BYTE; n_chr = r_line_rd; n_last = 1'b0;
                    n_idx = r_idx + 1'b1; n_state = S_EMIT_RD;
                end
            end
            S_OUT: begin
                if (!r_ovalid) begin
                    n_ocur = 6'(r_cursor); n_olen = 6'(r_len);
                    n_ovalid = 1'b1; n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_valid      = r_ovalid;
    assign o_kind       = r_kind;
    assign o_char_out   = r_chr;
    assign o_cursor_pos = r_ocur;
    assign o_line_len   = r_olen;
    assign o_overflow   = r_ovf;
    assign o_last       = r_last;

`include "terminal_line_editor_with_history_assert.svh"

    `TLE_ASSERT_IMP(a_cur_in_line, i_clk, i_rst_n, r_state == S_IDLE, r_cursor <= r_len, "cursor past end")
    `TLE_ASSERT_IMP(a_byte_not_last, i_clk, i_rst_n, o_valid && o_kind == KIND_BYTE, !o_last,
        "line byte marked last")
    `TLE_ASSERT_NXT(a_busy_after_take, i_clk, i_rst_n, i_valid && o_ready, !o_ready,
        "ready while busy")

endmodule
`default_nettype wire

// File: verif/tle_checker.sv
`timescale 1ns / 1ps
module tle_checker
    import tle_pkg::*;
#(
    parameter int LINE_CAP      = 63,
    parameter int HISTORY_DEPTH = 16
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    input  wire logic       i_in_ready,
    input  wire logic [7:0] i_key_byte,
    input  wire logic       i_out_valid,
    input  wire logic       i_ready,
    input  wire logic [2:0] i_kind,
    input  wire logic [7:0] i_char_out,
    input  wire logic [5:0] i_cursor_pos,
    input  wire logic [5:0] i_line_len,
    input  wire logic       i_overflow,
    input  wire logic       i_last,
    output int              o_errors,
    output int              o_pending,
    output int              o_lines,
    output int              o_beats
);

    typedef struct packed {
        logic [2:0] kind;
        logic [7:0] ch;
        logic [5:0] cur;
        logic [5:0] len;
        logic       ovf;
        logic       last;
    } t_beat;

    // Editor state mirror
    t_esc       esc_st;
    logic [7:0] line_buf [LINE_CAP];
    int         cur, len;
    logic [7:0] hist_buf [HISTORY_DEPTH][LINE_CAP];
    int         hist_len [HISTORY_DEPTH];
    bit         hist_ok  [HISTORY_DEPTH];
    int         wr_slot, view_slot;
    t_beat      exp_beats [$];

    function automatic t_beat mk(logic [2:0] k, logic [7:0] c, bit ovf);
        t_beat b;
        b.kind = k; b.ch = c; b.cur = cur[5:0]; b.len = len[5:0];
        b.ovf = ovf; b.last = 1'b0;
        return b;
    endfunction

    task automatic del_at_cursor();
        if (cur >= len) return;
        for (int i = cur; i + 1 < len; i++) line_buf[i] = line_buf[i + 1];
        len--;
    endtask

    task automatic backspace();
        if (cur == 0) return;
        cur--;
        del_at_cursor();
    endtask

    task automatic recall(int slot);
        view_slot = slot;
        if (slot == wr_slot) begin
            len = 0; cur = 0;
            return;
        end
        len = hist_len[slot];
        for (int i = 0; i < len; i++) line_buf[i] = hist_buf[slot][i];
        cur = len;
    endtask

    task automatic hist_up();
        int s;
        s = (view_slot + HISTORY_DEPTH - 1) % HISTORY_DEPTH;
        if (s == wr_slot || !hist_ok[s]) return;
        recall(s);
    endtask

    task automatic hist_down();
        if (view_slot == wr_slot) return;
        recall((view_slot + 1) % HISTORY_DEPTH);
    endtask

    task automatic fresh_line();
        cur = 0; len = 0; esc_st = ESC_IDLE; view_slot = wr_slot;
    endtask

    task automatic submit_line();
        int prv, n;
        bit same;
        logic [7:0] snap [LINE_CAP];
        t_beat b;
        while (len > 0 && line_buf[len - 1] == 8'h20) len--;
        prv = (wr_slot + HISTORY_DEPTH - 1) % HISTORY_DEPTH;
        n = len;
        for (int i = 0; i < n; i++) snap[i] = line_buf[i];
        same = hist_ok[prv] && hist_len[prv] == n;
        for (int i = 0; i < n && same; i++) if (hist_buf[prv][i] != line_buf[i]) same = 0;
        if (!(n == 0 || line_buf[0] == 8'h20 || same)) begin
            for (int i = 0; i < n; i++) hist_buf[wr_slot][i] = line_buf[i];
            hist_len[wr_slot] = n;
            hist_ok[wr_slot] = 1;
            wr_slot = (wr_slot + 1) % HISTORY_DEPTH;
        end
        fresh_line();
        for (int i = 0; i < n; i++) exp_beats.push_back(mk(KIND_BYTE, snap[i], 0));
        b = mk(KIND_DONE, 8'd0, 0);
        b.last = 1;
        exp_beats.push_back(b);
        o_lines++;
    endtask

    // Predict the beats one key byte causes
    task automatic predict_key(logic [7:0] c);
        t_esc st;
        bit ovf;
        t_beat b;
        st = esc_st;
        ovf = 0;
        if (c == KEY_ESC) begin
            esc_st = ESC_START;
        end else begin
            esc_st = ESC_IDLE;
            case (st)
                ESC_START: begin
                    if (c == "[") esc_st = ESC_CSI;
                    else if (c == "O") esc_st = ESC_SS3;
                end
                ESC_CSI: begin
                    case (c)
                        "A": hist_up();
                        "B": hist_down();
                        "C": if (cur < len) cur++;
                        "D": if (cur > 0) cur--;
                        "1": esc_st = ESC_ONE;
                        "3": esc_st = ESC_THREE;
                        "4": esc_st = ESC_FOUR;
                        "2", "5", "6": esc_st = ESC_SKIP;
                        default: ;
                    endcase
                end
                ESC_SS3: begin
                    if (c == "H") cur = 0;
                    if (c == "F") cur = len;
                end
                ESC_ONE: begin
                    if (c == ";") esc_st = ESC_SEMI;
                    if (c == "~") cur = 0;
                end
                ESC_THREE: if (c == "~") del_at_cursor();
                ESC_FOUR: if (c == "~") cur = len;
                ESC_SKIP: ;
                ESC_SEMI: if (c == "5") esc_st = ESC_MOD;
                ESC_MOD: begin
                    if (c == "C") cur = len;
                    if (c == "D") cur = 0;
                end
                default: begin
                    if (c == KEY_DEL) begin
                        backspace();
                    end else if (c < 32) begin
                        if (c == 10 || c == 13) begin
                            submit_line();
                            return;
                        end
                        if (c == 3 || (c == 4 && len == 0)) begin
                            fresh_line();
                            b = mk(c == 3 ? KIND_INTR : KIND_EOF, 8'd0, 0);
                            b.last = 1;
                            exp_beats.push_back(b);
                            return;
                        end
                        if (c == 4) del_at_cursor();
                        if (c == 1) cur = 0;
                        if (c == 2 && cur > 0) cur--;
                        if (c == 5) cur = len;
                        if (c == 6 && cur < len) cur++;
                        if (c == 8) backspace();
                        if (c == 14) hist_down();
                        if (c == 16) hist_up();
                    end else if (len >= LINE_CAP) begin
                        ovf = 1;
                    end else begin
                        for (int i = len; i > cur; i--) line_buf[i] = line_buf[i - 1];
                        line_buf[cur] = c;
                        cur++;
                        len++;
                    end
                end
            endcase
        end
        b = mk(KIND_STATUS, 8'd0, ovf);
        b.last = 1;
        exp_beats.push_back(b);
    endtask

    // Watch both channels and compare each result beat
    always @(posedge i_clk) begin
        t_beat got, want;
        if (!i_rst_n) begin
            fresh_line();
            wr_slot = 0; view_slot = 0;
            foreach (hist_ok[i]) hist_ok[i] = 0;
            exp_beats.delete();
            o_errors <= 0; o_lines <= 0; o_beats <= 0;
        end else begin
            if (i_out_valid && i_ready) begin
                got = '{i_kind, i_char_out, i_cursor_pos, i_line_len, i_overflow, i_last};
                o_beats <= o_beats + 1;
                if (exp_beats.size() == 0) begin
                    $display("%0t: unexpected beat %p", $realtime, got);
                    o_errors <= o_errors + 1;
                end else begin
                    want = exp_beats.pop_front();
                    if (got !== want) begin
                        $display("%0t: expected %p actual %p", $realtime, want, got);
                        o_errors <= o_errors + 1;
                    end
                end
            end
            if (i_valid && i_in_ready) predict_key(i_key_byte);
        end
        o_pending <= exp_beats.size();
    end

endmodule

// File: verif/tb_top.sv
`timescale 1ns / 1ps
module tb_top
    import tle_pkg::*;
();

    logic       i_clk, i_rst_n;
    logic       i_valid, i_ready;
    logic [7:0] i_key_byte;
    wire        o_ready, o_valid, o_overflow, o_last;
    wire [2:0]  o_kind;
    wire [7:0]  o_char_out;
    wire [5:0]  o_cursor_pos, o_line_len;
    int         errors, pending, lines, beats;
    int         send_idle_pct, recv_idle_pct;
    bit         hold_off;
    int         keys_sent;

    terminal_line_editor_with_history uut (.*);

    tle_checker chk (
        .i_clk, .i_rst_n, .i_valid, .i_in_ready(o_ready), .i_key_byte,
        .i_out_valid(o_valid), .i_ready, .i_kind(o_kind), .i_char_out(o_char_out),
        .i_cursor_pos(o_cursor_pos), .i_line_len(o_line_len),
        .i_overflow(o_overflow), .i_last(o_last),
        .o_errors(errors), .o_pending(pending), .o_lines(lines), .o_beats(beats)
    );

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    // Receiver: random stalls, plus a long hold-off window
    always @(posedge i_clk) begin
        if (!i_rst_n) i_ready <= 0;
        else i_ready <= !hold_off && ($urandom_range(99) >= recv_idle_pct);
    end

    // Offer one key byte and wait until it is accepted
    task automatic send_key(logic [7:0] c);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 0;
            @(posedge i_clk);
        end
        i_valid <= 1;
        i_key_byte <= c;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        keys_sent++;
    endtask

    task automatic send_str(string s);
        for (int i = 0; i < s.len(); i++) send_key(s[i]);
    endtask

    task automatic drain();
        i_valid <= 0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    // Random key: printable bytes most often, with edits, moves and escape sequences
    task automatic random_key();
        int r;
        string ss3_keys;
        ss3_keys = "HFX";
        r = $urandom_range(99);
        if (r < 45) send_key(8'($urandom_range(32, 126)));
        else if (r < 52) send_key(8'($urandom_range(128, 255)));
        else if (r < 60) send_key(8'($urandom_range(0, 31)));
        else if (r < 64) send_key(KEY_DEL);
        else if (r < 70) send_key(13);
        else if (r < 80) begin
            send_key(KEY_ESC); send_key("[");
            send_key(8'("A" + $urandom_range(3)));
        end else if (r < 85) begin
            send_key(KEY_ESC); send_key("O"); send_key(ss3_keys[$urandom_range(2)]);
        end else if (r < 92) begin
            send_key(KEY_ESC); send_key("[");
            send_key(8'("1" + $urandom_range(5)));
            if ($urandom_range(1)) send_key("~");
            else begin
                send_key(";"); send_key("5"); send_key(8'("C" + $urandom_range(1)));
            end
        end else send_key(8'($urandom));
    endtask

    initial begin
        i_rst_n = 0; i_valid = 0; i_key_byte = 0; hold_off = 0;
        send_idle_pct = 0; recv_idle_pct = 0; keys_sent = 0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // Directed: edits, history, escapes, interrupt, end of input
        send_key(4);
        send_str("ab"); send_key(2); send_key("X"); send_key(1); send_key(4);
        send_key(5); send_key(8); send_str("  "); send_key(13);
        send_str("cd"); send_key(10);
        send_str("cd"); send_key(13);
        send_str(" sp"); send_key(13);
        send_key(16); send_key(16); send_key(16); send_key(14); send_key(14);
        send_key(14);
        send_key(KEY_ESC); send_key("["); send_key("A");
        send_key(KEY_ESC); send_key("["); send_key("D");
        send_key(KEY_ESC); send_key("["); send_key("3"); send_key("~");
        send_key(KEY_ESC); send_key("O"); send_key("H");
        send_key(KEY_ESC); send_key("["); send_key("1"); send_key(";");
        send_key("5"); send_key("C");
        send_key(KEY_ESC); send_key(KEY_ESC); send_key("["); send_key("2");
        send_key("z"); send_key(6); send_key(3);
        send_key(8'hff); send_key(0);
        drain();

        // Fill the line past capacity with the receiver held off
        hold_off <= 1;
        fork
            for (int i = 0; i < 66; i++) send_key(8'h80 | 8'(i));
            begin
                repeat (300) @(posedge i_clk);
                hold_off <= 0;
            end
        join
        send_key(KEY_ESC); send_key("["); send_key("4"); send_key("~");
        send_key(13);
        drain();

        send_idle_pct = 21; recv_idle_pct = 52;
        while (keys_sent < 160) random_key();
        drain();
        send_idle_pct = 52; recv_idle_pct = 21;
        while (keys_sent < 190) random_key();
        send_idle_pct = 0; recv_idle_pct = 0;
        while (keys_sent < 220) random_key();
        send_key(13);
        drain();

        $display("Sent %0d key bytes; %0d lines submitted, %0d result beats checked.",
                 keys_sent, lines, beats);
        $display("Covered escapes, history recall, overflow and idle/stall mixes.");
        if (errors == 0) $display("terminal_line_editor_with_history: match");
        else $display("terminal_line_editor_with_history: mismatch");
        $finish;
    end

    initial begin
        #20ms;
        $display("terminal_line_editor_with_history: mismatch");
        $finish;
    end

endmodule

// File: terminal_line_editor_with_history.f
+incdir+src
src/tle_pkg.sv
src/terminal_line_editor_with_history.sv
verif/tle_checker.sv
verif/tb_top.sv
